// ===== design/srsw_pkg.sv =====
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants of the selective-repeat send window.
// ----------------------------------------------------------------------------
package srsw_pkg;

    localparam int NUM_CONN   = 4;
    localparam int CONN_W     = 2;
    localparam int WIN_SLOTS  = 32;
    localparam int SLOT_W     = 5;
    localparam int CNT_W      = SLOT_W + 1;
    localparam int ADDR_W     = CONN_W + SLOT_W;
    localparam int DEPTH      = NUM_CONN * WIN_SLOTS;
    localparam int LEN_W      = 11;
    localparam int MAX_CHUNK  = 1024;
    localparam int SEQ_W      = 32;
    localparam int LIMIT_W    = 6;
    localparam int TMO_W      = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd10;
    localparam logic [TMO_W-1:0]   TMO_RESET   = 16'd10;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_SCAN = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_REFUSED = 2'd0,
        KIND_NEW     = 2'd1,
        KIND_RESEND  = 2'd2
    } kind_t;

    typedef enum logic [0:0] {
        REG_LIMIT   = 1'b0,
        REG_TIMEOUT = 1'b1
    } reg_idx_t;

    // Classified request handed from front to back
    typedef struct packed {
        op_t               op;
        logic [CONN_W-1:0] conn;
        logic [SEQ_W-1:0]  ack;
        logic [LEN_W-1:0]  len;
        logic [SEQ_W-1:0]  now;
    } req_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] limit;
        logic [TMO_W-1:0]   timeout;
    } cfg_t;

endpackage

// ===== design/srsw_front.sv =====
// ----------------------------------------------------------------------------
// srsw_front
// Accepts requests, drops those without effect, clamps lengths and queues
// the rest for the back end. Holds the configuration registers.
// ----------------------------------------------------------------------------
module srsw_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [srsw_pkg::CONN_W-1:0] conn_id,
    input  logic [srsw_pkg::SEQ_W-1:0]  ack_seq,
    input  logic [srsw_pkg::LEN_W-1:0]  chunk_len,
    input  logic [srsw_pkg::SEQ_W-1:0]  now_ms,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [31:0]                 cfg_data,
    output srsw_pkg::cfg_t              cfg,
    output logic                        q_valid,
    output srsw_pkg::req_t              q_req,
    input  logic                        q_pop
);
    import srsw_pkg::*;

    req_t               q_mem_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [TMO_W-1:0]   tmo_reg;
    req_t               req;
    logic               keep, push;

    assign cfg_ready = 1'b1;
    assign cfg.limit = limit_reg;
    assign cfg.timeout = tmo_reg;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            tmo_reg   <= TMO_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_LIMIT:   limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_TIMEOUT: tmo_reg   <= cfg_data[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify: drop idle opcode and empty sends, clamp length
    always_comb
    begin
        req.op   = op_t'(operation);
        req.conn = conn_id;
        req.ack  = ack_seq;
        req.now  = now_ms;
        req.len  = (chunk_len > LEN_W'(MAX_CHUNK)) ? LEN_W'(MAX_CHUNK) : chunk_len;
        keep     = (req.op != OP_NONE) && !(req.op == OP_SEND && chunk_len == '0);
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_req    = q_mem_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= req;
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

// ===== design/srsw_back.sv =====
// ----------------------------------------------------------------------------
// srsw_back
// Executes queued requests against the per-connection window state and the
// slot memories, and drives the result register.
// ----------------------------------------------------------------------------
module srsw_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  srsw_pkg::cfg_t              cfg,
    input  logic                        q_valid,
    input  srsw_pkg::req_t              q_req,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  kind,
    output logic [srsw_pkg::CONN_W-1:0] out_conn,
    output logic [srsw_pkg::SEQ_W-1:0]  out_seq,
    output logic [srsw_pkg::LEN_W-1:0]  out_len,
    output logic                        last_of_run
);
    import srsw_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SLIDE = 5'b00010,
        ST_RD    = 5'b00100,
        ST_EV    = 5'b01000,
        ST_END   = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [NUM_CONN-1:0][SEQ_W-1:0]  base_reg, base_next;
    logic [NUM_CONN-1:0][SEQ_W-1:0]  next_reg, next_next;
    logic [DEPTH-1:0]                pend_reg, pend_next;
    logic [LEN_W-1:0]                len_mem [DEPTH];
    logic [SEQ_W-1:0]                time_mem [DEPTH];
    logic [LEN_W-1:0]                rd_len_reg;
    logic [SEQ_W-1:0]                rd_time_reg;
    logic [CONN_W-1:0]               conn_reg, conn_next;
    logic [SEQ_W-1:0]                now_reg, now_next;
    logic [CNT_W-1:0]                idx_reg, idx_next, cnt_reg, cnt_next;
    logic                            held_reg, held_next;
    logic [SEQ_W-1:0]                held_seq_reg, held_seq_next;
    logic [LEN_W-1:0]                held_len_reg, held_len_next;
    logic                            ov_reg, ov_next;
    logic [1:0]                      kind_reg, kind_next;
    logic [CONN_W-1:0]               oc_reg, oc_next;
    logic [SEQ_W-1:0]                os_reg, os_next;
    logic [LEN_W-1:0]                ol_reg, ol_next;
    logic                            olast_reg, olast_next;
    logic                            can_load;
    logic [SEQ_W-1:0]                qb, qn, outst, cb, cn, scan_seq;
    logic [CNT_W-1:0]                eff;
    logic                            len_we, time_we, rd_en;
    logic [ADDR_W-1:0]               wr_addr, rd_addr, ack_addr;
    logic [SEQ_W-1:0]                time_wd;

    assign out_valid   = ov_reg;
    assign kind        = kind_reg;
    assign out_conn    = oc_reg;
    assign out_seq     = os_reg;
    assign out_len     = ol_reg;
    assign last_of_run = olast_reg;

    assign can_load = !ov_reg || out_ready;
    assign qb       = base_reg[q_req.conn];
    assign qn       = next_reg[q_req.conn];
    assign outst    = qn - qb;
    assign eff      = (cfg.limit > LIMIT_W'(WIN_SLOTS)) ? CNT_W'(WIN_SLOTS) : CNT_W'(cfg.limit);
    assign cb       = base_reg[conn_reg];
    assign cn       = next_reg[conn_reg];
    assign scan_seq = cb + SEQ_W'(idx_reg);
    assign ack_addr = {q_req.conn, q_req.ack[SLOT_W-1:0]};
    assign rd_addr  = {conn_reg, scan_seq[SLOT_W-1:0]};

    always_comb
    begin
        state_next    = state_reg;
        base_next     = base_reg;
        next_next     = next_reg;
        pend_next     = pend_reg;
        conn_next     = conn_reg;
        now_next      = now_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        held_next     = held_reg;
        held_seq_next = held_seq_reg;
        held_len_next = held_len_reg;
        ov_next       = ov_reg && !out_ready;
        kind_next     = kind_reg;
        oc_next       = oc_reg;
        os_next       = os_reg;
        ol_next       = ol_reg;
        olast_next    = olast_reg;
        q_pop         = 1'b0;
        len_we        = 1'b0;
        time_we       = 1'b0;
        rd_en         = 1'b0;
        wr_addr       = {q_req.conn, qn[SLOT_W-1:0]};
        time_wd       = q_req.now;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_req.op)
                        OP_SEND:
                        begin
                            if (can_load)
                            begin
                                q_pop      = 1'b1;
                                ov_next    = 1'b1;
                                oc_next    = q_req.conn;
                                os_next    = qn;
                                ol_next    = q_req.len;
                                olast_next = 1'b1;
                                if (outst >= SEQ_W'(eff))
                                    kind_next = KIND_REFUSED;
                                else
                                begin
                                    kind_next            = KIND_NEW;
                                    len_we               = 1'b1;
                                    time_we              = 1'b1;
                                    pend_next[wr_addr]   = 1'b1;
                                    next_next[q_req.conn] = qn + 1'b1;
                                end
                            end
                        end
                        OP_ACK:
                        begin
                            q_pop = 1'b1;
                            if ((q_req.ack - qb) < outst)
                            begin
                                pend_next[ack_addr] = 1'b0;
                                conn_next           = q_req.conn;
                                state_next          = ST_SLIDE;
                            end
                        end
                        default:
                        begin
                            q_pop      = 1'b1;
                            conn_next  = q_req.conn;
                            now_next   = q_req.now;
                            idx_next   = '0;
                            cnt_next   = (outst > SEQ_W'(WIN_SLOTS)) ? CNT_W'(WIN_SLOTS)
                                                                     : outst[CNT_W-1:0];
                            held_next  = 1'b0;
                            state_next = ST_RD;
                        end
                    endcase
                end
            end
            // Slide base past acknowledged slots
            ST_SLIDE:
            begin
                if (cb != cn && !pend_reg[{conn_reg, cb[SLOT_W-1:0]}])
                    base_next[conn_reg] = cb + 1'b1;
                else
                    state_next = ST_IDLE;
            end
            // Walk slots, read pending ones
            ST_RD:
            begin
                if (idx_reg == cnt_reg)
                    state_next = ST_END;
                else if (pend_reg[rd_addr])
                begin
                    rd_en      = 1'b1;
                    state_next = ST_EV;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            // Check age; hold one due result back to mark the last
            ST_EV:
            begin
                if ((now_reg - rd_time_reg) <= SEQ_W'(cfg.timeout))
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD;
                end
                else if (!held_reg || can_load)
                begin
                    if (held_reg)
                    begin
                        ov_next    = 1'b1;
                        kind_next  = KIND_RESEND;
                        oc_next    = conn_reg;
                        os_next    = held_seq_reg;
                        ol_next    = held_len_reg;
                        olast_next = 1'b0;
                    end
                    time_we       = 1'b1;
                    wr_addr       = rd_addr;
                    time_wd       = now_reg;
                    held_next     = 1'b1;
                    held_seq_next = scan_seq;
                    held_len_next = rd_len_reg;
                    idx_next      = idx_reg + 1'b1;
                    state_next    = ST_RD;
                end
            end
            // Flush the held result as the last one
            ST_END:
            begin
                if (!held_reg)
                    state_next = ST_IDLE;
                else if (can_load)
                begin
                    ov_next    = 1'b1;
                    kind_next  = KIND_RESEND;
                    oc_next    = conn_reg;
                    os_next    = held_seq_reg;
                    ol_next    = held_len_reg;
                    olast_next = 1'b1;
                    held_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Slot memories
    always_ff @(posedge clk)
    begin
        if (len_we)
            len_mem[wr_addr] <= q_req.len;
        if (time_we)
            time_mem[wr_addr] <= time_wd;
        if (rd_en)
        begin
            rd_len_reg  <= len_mem[rd_addr];
            rd_time_reg <= time_mem[rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        held_seq_reg <= held_seq_next;
        held_len_reg <= held_len_next;
        kind_reg     <= kind_next;
        oc_reg       <= oc_next;
        os_reg       <= os_next;
        ol_reg       <= ol_next;
        olast_reg    <= olast_next;
        conn_reg     <= conn_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            base_reg  <= '0;
            next_reg  <= '0;
            pend_reg  <= '0;
            held_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            next_reg  <= next_next;
            pend_reg  <= pend_next;
            held_reg  <= held_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// ===== design/selective_repeat_send_window.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_send_window
// Selective-repeat sender window tracker for four connections.
//
//   channel  signals                            direction
//   input    in_valid/in_ready + request fields into block
//   config   cfg_valid/cfg_ready, index, data   into block
//   output   out_valid/out_ready + result fields out of block
//
// Every request is written into the queue before the back end takes it.
// A send is handled from the idle state and loads its result straight into
// the output register; an ack clears its pending mark, then slides the base
// past acknowledged slots (an out-of-window ack is only dropped); a scan
// walks the window slot by slot and reads the memories of each pending slot.
// Reset clears window state and pending marks; no clearing pass is needed.
// A two-entry queue lets requests arrive while the back end works or waits
// on a stalled output.
// ----------------------------------------------------------------------------
module selective_repeat_send_window (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [srsw_pkg::CONN_W-1:0] conn_id,
    input  logic [srsw_pkg::SEQ_W-1:0]  ack_seq,
    input  logic [srsw_pkg::LEN_W-1:0]  chunk_len,
    input  logic [srsw_pkg::SEQ_W-1:0]  now_ms,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [31:0]                 cfg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  kind,
    output logic [srsw_pkg::CONN_W-1:0] out_conn,
    output logic [srsw_pkg::SEQ_W-1:0]  out_seq,
    output logic [srsw_pkg::LEN_W-1:0]  out_len,
    output logic                        last_of_run
);
    import srsw_pkg::*;

    cfg_t cfg;
    logic q_valid, q_pop;
    req_t q_req;

    srsw_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .conn_id(conn_id), .ack_seq(ack_seq),
        .chunk_len(chunk_len), .now_ms(now_ms),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg),
        .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
    );

    srsw_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .out_conn(out_conn), .out_seq(out_seq),
        .out_len(out_len), .last_of_run(last_of_run)
    );

endmodule
